// File: sv/sct_pkg.sv
// Shared types, constants and helpers for the shell command tokenizer.
// Depends on nothing; the front end, queue, back end, top level and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

	// Result kinds as they appear on the output channel.
	typedef enum logic [2:0] {
		K_LIT      = 3'd0,
		K_NAME     = 3'd1,
		K_NAME_END = 3'd2,
		K_TOK_END  = 3'd3,
		K_CMD_END  = 3'd4
	} kind_t;

	// Characters with a meaning of their own to the parser.
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int MAX_RES = 4;
	localparam int QDEPTH  = 4;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// All results caused by one input beat, in order; cnt is 0 to 4, and only bundles with a nonzero cnt are queued.
	typedef struct packed {
		logic [2:0]             cnt;
		res_t [MAX_RES-1:0]     res;
	} bundle_t;

	// Appends one result; anything beyond four is dropped.
	function automatic bundle_t push_res(bundle_t b, kind_t k, logic [7:0] d);
		bundle_t r;
		r = b;
		if (!b.cnt[2]) begin
			r.res[b.cnt[1:0]].kind = k;
			r.res[b.cnt[1:0]].data = d;
			r.cnt = b.cnt + 3'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/sct_req_if.sv
// Input channel of the tokenizer: one command-line byte and its flags per beat.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface sct_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       has_byte;
	logic       final_req;

	modport source (output valid, output in_byte, output has_byte, output final_req,
		input ready);
	modport sink (input valid, input in_byte, input has_byte, input final_req,
		output ready);
endinterface

`default_nettype wire

// File: sv/sct_tok_if.sv
// Output channel of the tokenizer: one token mark per beat.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface sct_tok_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output kind, output out_byte, output last,
		input ready);
	modport sink (input valid, input kind, input out_byte, input last,
		output ready);
endinterface

`default_nettype wire

// File: sv/sct_front.sv
// Front end: accepts input beats, runs the parse-mode machine and bundles the
// results of each beat. Depends on sct_pkg and sct_req_if.
`timescale 1ns / 1ps
`default_nettype none

module sct_front
	import sct_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	sct_req_if.sink      req,
	output logic         bnd_valid,
	input  wire logic    bnd_ready,
	output bundle_t      bnd
);

	typedef enum logic [2:0] {
		M_NORMAL = 3'd0,
		M_DQUOTE = 3'd1,
		M_ESCAPE = 3'd2,
		M_NAME   = 3'd3,
		M_SQUOTE = 3'd4
	} mode_t;

	mode_t mode_q;
	logic  rtq_q, tok_q, cmd_q, nam_q;

	mode_t   m;
	logic    rtq, tok, cmd, nam, skip;
	bundle_t b;
	logic    acc;

	function automatic logic is_name_char(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39) || c == CH_USCORE;
	endfunction

	always_comb begin
		m    = mode_q;
		rtq  = rtq_q;
		tok  = tok_q;
		cmd  = cmd_q;
		nam  = nam_q;
		skip = 1'b0;
		b    = '0;

		if (req.has_byte) begin
			if (m == M_NAME) begin
				if (is_name_char(req.in_byte)) begin
					b    = push_res(b, K_NAME, req.in_byte);
					nam  = 1'b1;
					tok  = 1'b1;
					skip = 1'b1;
				end else begin
					// An empty name stands for a literal dollar sign.
					if (nam) begin
						b = push_res(b, K_NAME_END, 8'h00);
					end else begin
						b   = push_res(b, K_LIT, CH_DOLLAR);
						tok = 1'b1;
					end
					nam = 1'b0;
					m   = rtq ? M_DQUOTE : M_NORMAL;
					rtq = 1'b0;
				end
			end

			if (!skip) begin
				unique case (m)
					M_DQUOTE: begin
						if (req.in_byte == CH_DQUOTE) begin
							m = M_NORMAL;
						end else if (req.in_byte == CH_BSLASH) begin
							m   = M_ESCAPE;
							rtq = 1'b1;
						end else if (req.in_byte == CH_DOLLAR) begin
							m   = M_NAME;
							rtq = 1'b1;
							nam = 1'b0;
						end else begin
							b   = push_res(b, K_LIT, req.in_byte);
							tok = 1'b1;
						end
					end
					M_ESCAPE: begin
						if (!rtq) begin
							if (req.in_byte != CH_LF) begin
								b   = push_res(b, K_LIT, req.in_byte);
								tok = 1'b1;
							end
							m = M_NORMAL;
						end else begin
							// Inside double quotes only a few characters lose the backslash.
							if (!(req.in_byte == CH_DOLLAR || req.in_byte == CH_BTICK ||
								req.in_byte == CH_DQUOTE || req.in_byte == CH_BSLASH)) begin
								b = push_res(b, K_LIT, CH_BSLASH);
							end
							b   = push_res(b, K_LIT, req.in_byte);
							tok = 1'b1;
							m   = M_DQUOTE;
						end
						rtq = 1'b0;
					end
					M_SQUOTE: begin
						if (req.in_byte == CH_SQUOTE) begin
							m = M_NORMAL;
						end else begin
							b   = push_res(b, K_LIT, req.in_byte);
							tok = 1'b1;
						end
					end
					default: begin
						m = M_NORMAL;
						case (req.in_byte) inside
							CH_BSLASH: begin
								m   = M_ESCAPE;
								rtq = 1'b0;
							end
							CH_DQUOTE: m = M_DQUOTE;
							CH_DOLLAR: begin
								m   = M_NAME;
								rtq = 1'b0;
								nam = 1'b0;
							end
							CH_SPACE: begin
								if (tok) begin
									b   = push_res(b, K_TOK_END, 8'h00);
									tok = 1'b0;
									cmd = 1'b1;
								end
							end
							CH_SQUOTE: m = M_SQUOTE;
							CH_SEMI, CH_LF: begin
								if (tok) begin
									b   = push_res(b, K_TOK_END, 8'h00);
									tok = 1'b0;
									cmd = 1'b1;
								end
								if (cmd) begin
									b   = push_res(b, K_CMD_END, 8'h00);
									cmd = 1'b0;
								end
							end
							default: begin
								b   = push_res(b, K_LIT, req.in_byte);
								tok = 1'b1;
							end
						endcase
					end
				endcase
			end
		end

		if (req.final_req) begin
			if (m == M_NAME) begin
				if (nam) begin
					b = push_res(b, K_NAME_END, 8'h00);
				end else begin
					b   = push_res(b, K_LIT, CH_DOLLAR);
					tok = 1'b1;
				end
			end
			if (tok) begin
				b   = push_res(b, K_TOK_END, 8'h00);
				tok = 1'b0;
				cmd = 1'b1;
			end
			if (cmd) begin
				b   = push_res(b, K_CMD_END, 8'h00);
				cmd = 1'b0;
			end
			m   = M_NORMAL;
			rtq = 1'b0;
			nam = 1'b0;
		end
	end

	assign req.ready = bnd_ready;
	assign acc       = req.valid && bnd_ready;
	assign bnd_valid = req.valid && (b.cnt != 3'd0);
	assign bnd       = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			rtq_q  <= 1'b0;
			tok_q  <= 1'b0;
			cmd_q  <= 1'b0;
			nam_q  <= 1'b0;
		end else if (acc) begin
			mode_q <= m;
			rtq_q  <= rtq;
			tok_q  <= tok;
			cmd_q  <= cmd;
			nam_q  <= nam;
		end
	end

endmodule

`default_nettype wire

// File: sv/sct_queue.sv
// Small queue of result bundles between the front and back ends.
// Depends on sct_pkg for the bundle type.
`timescale 1ns / 1ps
`default_nettype none

module sct_queue
	import sct_pkg::*;
#(
	parameter int DEPTH = QDEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr_valid,
	output logic         wr_ready,
	input  wire bundle_t wr_data,
	output logic         rd_valid,
	input  wire logic    rd_ready,
	output bundle_t      rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   cnt_q;
	logic            wr, rd;

	assign wr_ready = (cnt_q != CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/sct_back.sv
// Back end: unpacks one bundle at a time into single output beats and marks
// the last beat of each input item. Depends on sct_pkg and sct_tok_if.
`timescale 1ns / 1ps
`default_nettype none

module sct_back
	import sct_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    bnd_valid,
	output logic         bnd_ready,
	input  wire bundle_t bnd,
	sct_tok_if.source    tok
);

	bundle_t    cur_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       at_end;

	assign at_end    = ({1'b0, idx_q} == cur_q.cnt - 3'd1);
	// The next bundle is taken when none is held or as the last beat of the current one leaves.
	assign bnd_ready = !valid_q || (tok.ready && at_end);

	assign tok.valid    = valid_q;
	assign tok.kind     = cur_q.res[idx_q].kind;
	assign tok.out_byte = cur_q.res[idx_q].data;
	assign tok.last     = at_end;

	always_ff @(posedge clk) begin
		if (bnd_valid && bnd_ready) begin
			cur_q <= bnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (bnd_ready) begin
			valid_q <= bnd_valid;
			idx_q   <= '0;
		end else if (tok.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// File: sv/shell_command_tokenizer.sv
// Top level of the shell command tokenizer: front end, bundle queue, back end.
// Depends on sct_pkg, sct_req_if, sct_tok_if, sct_front, sct_queue, sct_back.
//
//   channel | dir | beat carries
//   --------+-----+----------------------------------------------
//   req     | in  | in_byte, has_byte, final_req
//   tok     | out | kind, out_byte, last
//
// An input beat is taken every cycle while the queue has room; its results
// (up to four) are parsed in that cycle and queued as one bundle.
// The back end sends one result per cycle while the output is ready and a
// bundle is held, each result as a beat of its own on the output.
// Items that cause no result are taken at the input and queue nothing.
// arst_n returns the parser to normal mode and empties queue and output.
`timescale 1ns / 1ps
`default_nettype none

module shell_command_tokenizer
	import sct_pkg::*;
#(
	parameter int QUEUE_DEPTH = QDEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sct_req_if.sink      req,
	sct_tok_if.source    tok
);

	logic    f_valid, f_ready;
	bundle_t f_data;
	logic    b_valid, b_ready;
	bundle_t b_data;

	sct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.bnd_valid (f_valid),
		.bnd_ready (f_ready),
		.bnd       (f_data)
	);

	sct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	sct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.bnd_valid (b_valid),
		.bnd_ready (b_ready),
		.bnd       (b_data),
		.tok       (tok)
	);

endmodule

`default_nettype wire

// File: tb/sv/shell_command_tokenizer_tb.sv
// Self-checking testbench for the shell command tokenizer.
// Depends on sct_pkg, sct_req_if, sct_tok_if and the shell_command_tokenizer top level.
// A built-in parser model predicts every result beat, which is then checked in order.
`timescale 1ns / 1ps

module shell_command_tokenizer_tb;
	import sct_pkg::*;

	localparam int STALL_LIMIT  = 500;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [2:0] {
		PM_NORMAL = 3'd0,
		PM_DQUOTE = 3'd1,
		PM_ESCAPE = 3'd2,
		PM_NAME   = 3'd3,
		PM_SQUOTE = 3'd4
	} parse_mode_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} mark_t;

	logic clk;
	logic arst_n;

	sct_req_if req_ch ();
	sct_tok_if tok_ch ();

	shell_command_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.tok    (tok_ch)
	);

	// Parser state of the model.
	parse_mode_t pm;
	bit          back_to_dq;
	bit          tok_open;
	bit          cmd_open;
	bit          name_open;

	mark_t item_marks[$];
	mark_t pending_marks[$];

	bit idle_on;
	int mismatches;
	int items_sent;
	int marks_checked;
	int kind_count[5];
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic void put_mark(kind_t k, logic [7:0] d);
		mark_t m;
		if (item_marks.size() < MAX_RES) begin
			m.kind = k;
			m.data = d;
			m.last = 1'b0;
			item_marks.insert(item_marks.size(), m);
		end
	endfunction

	function automatic void put_lit(logic [7:0] c);
		put_mark(K_LIT, c);
		tok_open = 1'b1;
	endfunction

	function automatic void close_token();
		if (tok_open) begin
			put_mark(K_TOK_END, 8'h00);
			tok_open = 1'b0;
			cmd_open = 1'b1;
		end
	endfunction

	function automatic void close_command();
		close_token();
		if (cmd_open) begin
			put_mark(K_CMD_END, 8'h00);
			cmd_open = 1'b0;
		end
	endfunction

	// An empty variable name falls back to a literal dollar sign.
	function automatic void close_var();
		if (name_open)
			put_mark(K_NAME_END, 8'h00);
		else
			put_lit(CH_DOLLAR);
		name_open = 1'b0;
		pm = back_to_dq ? PM_DQUOTE : PM_NORMAL;
		back_to_dq = 1'b0;
	endfunction

	function automatic bit is_name_byte(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == CH_USCORE;
	endfunction

	function automatic void parse_byte(logic [7:0] c);
		if (pm == PM_NAME) begin
			if (is_name_byte(c)) begin
				put_mark(K_NAME, c);
				name_open = 1'b1;
				tok_open = 1'b1;
				return;
			end
			close_var();
		end
		case (pm)
			PM_DQUOTE: begin
				if (c == CH_DQUOTE) begin
					pm = PM_NORMAL;
				end else if (c == CH_BSLASH) begin
					pm = PM_ESCAPE;
					back_to_dq = 1'b1;
				end else if (c == CH_DOLLAR) begin
					pm = PM_NAME;
					back_to_dq = 1'b1;
					name_open = 1'b0;
				end else begin
					put_lit(c);
				end
			end
			PM_ESCAPE: begin
				if (!back_to_dq) begin
					if (c != CH_LF)
						put_lit(c);
					pm = PM_NORMAL;
				end else begin
					if (!(c == CH_DOLLAR || c == CH_BTICK || c == CH_DQUOTE || c == CH_BSLASH))
						put_lit(CH_BSLASH);
					put_lit(c);
					pm = PM_DQUOTE;
				end
				back_to_dq = 1'b0;
			end
			PM_SQUOTE: begin
				if (c == CH_SQUOTE)
					pm = PM_NORMAL;
				else
					put_lit(c);
			end
			default: begin
				pm = PM_NORMAL;
				if (c == CH_BSLASH) begin
					pm = PM_ESCAPE;
					back_to_dq = 1'b0;
				end else if (c == CH_DQUOTE) begin
					pm = PM_DQUOTE;
				end else if (c == CH_DOLLAR) begin
					pm = PM_NAME;
					back_to_dq = 1'b0;
					name_open = 1'b0;
				end else if (c == CH_SPACE) begin
					close_token();
				end else if (c == CH_SQUOTE) begin
					pm = PM_SQUOTE;
				end else if (c == CH_SEMI || c == CH_LF) begin
					close_command();
				end else begin
					put_lit(c);
				end
			end
		endcase
	endfunction

	function automatic void predict_marks(logic [7:0] c, bit has, bit fin);
		item_marks.delete();
		if (has)
			parse_byte(c);
		if (fin) begin
			if (pm == PM_NAME)
				close_var();
			close_command();
			pm = PM_NORMAL;
			back_to_dq = 1'b0;
			name_open = 1'b0;
		end
		if (item_marks.size() > 0)
			item_marks[item_marks.size() - 1].last = 1'b1;
		foreach (item_marks[i])
			pending_marks.insert(pending_marks.size(), item_marks[i]);
	endfunction

	// ------------------------------------------------------------- stimulus

	task automatic send_item(input logic [7:0] b, input bit has, input bit fin);
		int gap;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.in_byte = b;
		req_ch.has_byte = has;
		req_ch.final_req = fin;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_marks(b, has, fin);
		items_sent++;
	endtask

	task automatic send_text(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, fin && i == s.len() - 1);
	endtask

	// Biased towards characters that steer the parser, with some raw bytes mixed in.
	function automatic logic [7:0] pick_line_byte();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			case ($urandom_range(0, 3))
				0: c = "a" + 8'($urandom_range(0, 25));
				1: c = "A" + 8'($urandom_range(0, 25));
				2: c = "0" + 8'($urandom_range(0, 9));
				default: c = CH_USCORE;
			endcase
		end else if (r < 40) c = CH_SPACE;
		else if (r < 45) c = CH_SEMI;
		else if (r < 48) c = CH_LF;
		else if (r < 56) c = CH_DQUOTE;
		else if (r < 62) c = CH_SQUOTE;
		else if (r < 70) c = CH_BSLASH;
		else if (r < 80) c = CH_DOLLAR;
		else if (r < 84) c = CH_BTICK;
		else c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic test_plain_words();
		idle_on = 1'b1;
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_text(" ;;", 1'b0);
	endtask

	// Empty quotes start no token; an unterminated quote is closed at the line end.
	task automatic test_quoting();
		send_text("''\"\"", 1'b0);
		send_text("\"q", 1'b1);
	endtask

	task automatic test_escapes();
		send_text("\\\n\\A", 1'b0);
		send_text("\"\\n\\", 1'b1);
	endtask

	// Names entered from double quotes, an empty name and a flush giving four beats.
	task automatic test_variables();
		idle_on = 1'b0;
		send_text("\"$x\\\"", 1'b0);
		send_item(CH_DOLLAR, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_text("$Z", 1'b1);
	endtask

	task automatic test_line_ends();
		idle_on = 1'b1;
		send_text("x\n", 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hA5, 1'b0, 1'b1);
	endtask

	task automatic test_random_lines(input int n_items);
		int sent;
		int len;
		int ending;
		sent = 0;
		while (sent < n_items) begin
			// The second half runs back to back on both sides.
			idle_on = sent < n_items / 2;
			len = $urandom_range(1, 12);
			ending = $urandom_range(0, 7);
			for (int i = 0; i < len; i++)
				send_item(pick_line_byte(), 1'b1, ending < 5 && i == len - 1);
			if (ending == 5)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			sent += len;
		end
	endtask

	task automatic test_random_noise(input int n_items);
		idle_on = 1'b1;
		for (int i = 0; i < n_items; i++)
			send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) == 0);
	endtask

	task automatic finish_run();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_marks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d input beats and %0d checked result beats.",
			items_sent, marks_checked);
		$display("Beats by kind: literal %0d, name %0d, name end %0d, token end %0d, command end %0d.",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
		if (mismatches == 0)
			$display("shell_command_tokenizer_tb OK");
		else
			$display("shell_command_tokenizer_tb NOT OK");
		$finish;
	endtask

	// ---------------------------------------------------------- sink side

	initial begin : drain_tokens
		int hold;
		tok_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = idle_on ? $urandom_range(0, 10) : 0;
			@(negedge clk);
			if (hold > 0) begin
				tok_ch.ready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			tok_ch.ready = 1'b1;
			@(posedge clk);
			while (!tok_ch.valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_marks
		mark_t want;
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			marks_checked++;
			if (tok_ch.kind < 3'd5)
				kind_count[tok_ch.kind]++;
			if (pending_marks.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, got kind %0d byte %02h last %0b",
					$time, tok_ch.kind, tok_ch.out_byte, tok_ch.last);
			end else begin
				want = pending_marks.pop_front();
				if (tok_ch.kind !== want.kind) begin
					mismatches++;
					$display("%0t: kind mismatch, expected %0d, got %0d",
						$time, want.kind, tok_ch.kind);
				end
				if (tok_ch.out_byte !== want.data) begin
					mismatches++;
					$display("%0t: out_byte mismatch, expected %02h, got %02h",
						$time, want.data, tok_ch.out_byte);
				end
				if (tok_ch.last !== want.last) begin
					mismatches++;
					$display("%0t: last mismatch, expected %0b, got %0b",
						$time, want.last, tok_ch.last);
				end
			end
		end
	end

	// The run is abandoned when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles, %0d result beats outstanding",
					$time, STALL_LIMIT, pending_marks.size());
				$display("shell_command_tokenizer_tb NOT OK");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- main

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.in_byte = 8'h00;
		req_ch.has_byte = 1'b0;
		req_ch.final_req = 1'b0;
		idle_on = 1'b1;
		mismatches = 0;
		items_sent = 0;
		marks_checked = 0;
		quiet_cycles = 0;
		pm = PM_NORMAL;
		back_to_dq = 1'b0;
		tok_open = 1'b0;
		cmd_open = 1'b0;
		name_open = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_words();
		test_quoting();
		test_escapes();
		test_variables();
		test_line_ends();
		test_random_lines(175);
		test_random_noise(40);
		finish_run();
	end

endmodule
